>>> hdl/afs_pkg.sv
// ============================================================================
// afs_pkg
// Shared widths, codes and helpers of the animation frame sequencer.
// ============================================================================
`default_nettype none

package afs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int FRAME_W    = 8;
    localparam int TOTAL_W    = 9;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int PASS_W     = 16;
    localparam int PASS_LEN_W = DELAY_W + FRAME_W;
    localparam int PROD_W     = PASS_W + PASS_LEN_W;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ONCE     = 3'd4;

    // a zero delay lasts one millisecond
    function automatic logic [DELAY_W-1:0] eff_delay(input logic [DELAY_W-1:0] raw);
        eff_delay = (raw == '0) ? DELAY_W'(1) : raw;
    endfunction

endpackage

`default_nettype wire

>>> hdl/afs_delay_ram.sv
// ============================================================================
// afs_delay_ram
// Per-frame delay store, one write port and one registered read port.
// ============================================================================
`default_nettype none

module afs_delay_ram (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [afs_pkg::FRAME_W-1:0]  wr_addr,
    input  wire logic [afs_pkg::DELAY_W-1:0]  wr_data,
    input  wire logic [afs_pkg::FRAME_W-1:0]  rd_addr,
    output logic      [afs_pkg::DELAY_W-1:0]  rd_data
);

    logic [afs_pkg::DELAY_W-1:0] mem [afs_pkg::MAX_FRAMES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/afs_div.sv
// ============================================================================
// afs_div
// Restoring divider, one quotient bit per cycle, for whole-pass skipping.
// ============================================================================
`default_nettype none

module afs_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [afs_pkg::TIME_W-1:0]      dividend,
    input  wire logic [afs_pkg::PASS_LEN_W-1:0]  divisor,
    output logic                                 done,
    output logic      [afs_pkg::TIME_W-1:0]      quotient,
    output logic      [afs_pkg::PASS_LEN_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(afs_pkg::TIME_W + 1);

    logic [CNT_W-1:0]                 count_reg;
    logic                             busy_reg;
    logic [afs_pkg::PASS_LEN_W-1:0]   divisor_reg;
    logic [afs_pkg::PASS_LEN_W:0]     trial;
    logic                             ge;

    assign trial = {remainder, quotient[afs_pkg::TIME_W-1]};
    assign ge    = trial >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done      <= 1'b0;
            count_reg <= '0;
        end else begin
            if (start) begin
                done        <= 1'b0;
                busy_reg    <= 1'b1;
                count_reg   <= '0;
                quotient    <= dividend;
                remainder   <= '0;
                divisor_reg <= divisor;
            end else if (busy_reg) begin
                remainder <= ge ? afs_pkg::PASS_LEN_W'(trial - {1'b0, divisor_reg})
                                : trial[afs_pkg::PASS_LEN_W-1:0];
                quotient  <= {quotient[afs_pkg::TIME_W-2:0], ge};
                count_reg <= count_reg + CNT_W'(1);
                done      <= (count_reg == CNT_W'(afs_pkg::TIME_W - 1));
                if (count_reg == CNT_W'(afs_pkg::TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/animation_frame_sequencer_unit.sv
// A walking time sample steps one frame per delay table read; a wrap also sums the active
// frame delays of one pass and divides, then multiplies and subtracts when the skip is capped.
// Throughput: one item at a time, s_ready low until the result is loaded; the frame walk
// is bound by one delay table read a cycle.
// Reset (aresetn, synchronous): registers and playback state clear, delay table undefined.
// ============================================================================
// animation_frame_sequencer_unit
// Steps animation frames from millisecond timestamps with a delay table.
// ============================================================================
`default_nettype none

module animation_frame_sequencer_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [afs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [afs_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [afs_pkg::KIND_W-1:0]       s_kind,
    input  wire logic [afs_pkg::TIME_W-1:0]       s_now_time,
    input  wire logic [afs_pkg::FRAME_W-1:0]      s_entry_index,
    input  wire logic [afs_pkg::DELAY_W-1:0]      s_entry_delay,
    // results
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [afs_pkg::FRAME_W-1:0]      m_frame_index,
    output logic                                  m_showing,
    output logic                                  m_finished
);

    localparam int TW = afs_pkg::TOTAL_W;
    localparam int FW = afs_pkg::FRAME_W;
    localparam int PW = afs_pkg::PASS_W;
    localparam int LW = afs_pkg::PASS_LEN_W;
    localparam int XW = afs_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_WALK, ST_SUM, ST_DIV, ST_MUL, ST_SUB, ST_RESULT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [TW-1:0]                 frame_total_reg;
    logic                          use_table_reg;
    logic [afs_pkg::DELAY_W-1:0]   uniform_delay_reg;
    logic [PW-1:0]                 loop_limit_reg;
    logic                          play_once_reg;

    // latched item
    logic [afs_pkg::KIND_W-1:0]    kind_reg;
    logic [XW-1:0]                 now_reg;
    logic [FW-1:0]                 idx_reg;
    logic [afs_pkg::DELAY_W-1:0]   dly_reg;

    // playback state
    logic                          started_reg;
    logic                          finished_reg;
    logic [FW-1:0]                 cur_reg;
    logic [XW-1:0]                 acc_reg;
    logic [XW-1:0]                 prev_reg;
    logic [PW-1:0]                 pass_reg;
    logic                          second_reg;   // walk after a pass skip

    // pass skip datapath
    logic [FW-1:0]                 sum_idx_reg;
    logic [LW-1:0]                 sum_reg;
    logic [PW-1:0]                 mul_k_reg;
    logic [XW-1:0]                 prod_reg;

    // table and divider
    logic                          ram_we;
    logic [FW-1:0]                 ram_rd_addr;
    logic [afs_pkg::DELAY_W-1:0]   ram_rd_data;
    logic                          div_start;
    logic                          div_done;
    logic [XW-1:0]                 div_quo;
    logic [LW-1:0]                 div_rem;

    // combinational helpers
    logic [TW-1:0]                 total_act;
    logic [afs_pkg::DELAY_W-1:0]   frame_delay;
    logic [XW-1:0]                 acc_added;
    logic [FW-1:0]                 cur_fix;
    logic                          covers;
    logic [TW-1:0]                 cur_inc;
    logic                          pass_end;
    logic [PW-1:0]                 pass_inc;
    logic                          stop_now;
    logic [FW-1:0]                 walk_cur_next;
    logic                          sum_last;
    logic [LW-1:0]                 sum_next;
    logic [PW-1:0]                 limit_left;
    logic [PW-1:0]                 cap;
    logic                          capped;
    logic [XW-1:0]                 k_final;
    logic [PW:0]                   pass_add;
    logic [PW-1:0]                 pass_skip;
    logic [afs_pkg::PROD_W-1:0]    mul_full;
    logic                          show;

    assign s_ready = (state_reg == ST_IDLE);

    // frame totals above the table depth play as the table depth
    assign total_act = (frame_total_reg > TW'(afs_pkg::MAX_FRAMES))
                     ? TW'(afs_pkg::MAX_FRAMES) : frame_total_reg;

    // delay of the frame whose table entry was read last cycle
    assign frame_delay = afs_pkg::eff_delay(use_table_reg ? ram_rd_data : uniform_delay_reg);

    assign acc_added = acc_reg + (now_reg - prev_reg);
    assign cur_fix   = ({1'b0, cur_reg} >= total_act) ? '0 : cur_reg;

    // one frame step of the walk
    assign covers   = acc_reg >= XW'(frame_delay);
    assign cur_inc  = {1'b0, cur_reg} + TW'(1);
    assign pass_end = cur_inc >= total_act;
    assign pass_inc = (pass_reg == '1) ? pass_reg : pass_reg + PW'(1);
    assign stop_now = play_once_reg || (loop_limit_reg != '0 && pass_inc >= loop_limit_reg);

    always_comb begin
        if (!covers) begin
            walk_cur_next = cur_reg;
        end else if (pass_end) begin
            walk_cur_next = stop_now ? FW'(total_act - TW'(1)) : '0;
        end else begin
            walk_cur_next = cur_inc[FW-1:0];
        end
    end

    // pass length sum
    assign sum_last = ({1'b0, sum_idx_reg} + TW'(1)) == total_act;
    assign sum_next = sum_reg + LW'(frame_delay);

    // whole passes skipped, capped so the loop limit is reached by a real step
    assign limit_left = (loop_limit_reg > pass_reg) ? loop_limit_reg - pass_reg : '0;
    assign cap        = (limit_left != '0) ? limit_left - PW'(1) : '0;
    assign capped     = (loop_limit_reg != '0) && (div_quo > XW'(cap));
    assign k_final    = capped ? XW'(cap) : div_quo;
    assign pass_add   = {1'b0, pass_reg} + {1'b0, k_final[PW-1:0]};
    assign pass_skip  = (k_final[XW-1:PW] != '0 || pass_add[PW]) ? '1 : pass_add[PW-1:0];

    assign mul_full = afs_pkg::PROD_W'(mul_k_reg) * afs_pkg::PROD_W'(sum_reg);

    assign show = (total_act != '0) && started_reg;

    // table read address: next frame to look at, presented the cycle before its delay is needed
    always_comb begin
        case (state_reg)
            ST_EXEC: ram_rd_addr = cur_fix;
            ST_WALK: ram_rd_addr = walk_cur_next;
            ST_SUM:  ram_rd_addr = sum_idx_reg + FW'(1);
            default: ram_rd_addr = cur_reg;
        endcase
    end

    assign ram_we    = (state_reg == ST_EXEC) && (kind_reg == afs_pkg::KIND_WRITE);
    assign div_start = (state_reg == ST_SUM) && sum_last;

    afs_delay_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (dly_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    afs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (acc_reg),
        .divisor   (sum_next),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_total_reg   <= '0;
            use_table_reg     <= 1'b0;
            uniform_delay_reg <= '0;
            loop_limit_reg    <= '0;
            play_once_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                afs_pkg::CFG_FRAME_TOTAL:   frame_total_reg   <= cfg_wr_data[TW-1:0];
                afs_pkg::CFG_USE_TABLE:     use_table_reg     <= cfg_wr_data[0];
                afs_pkg::CFG_UNIFORM_DELAY: uniform_delay_reg <= cfg_wr_data;
                afs_pkg::CFG_LOOP_LIMIT:    loop_limit_reg    <= cfg_wr_data;
                afs_pkg::CFG_PLAY_ONCE:     play_once_reg     <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            cur_reg      <= '0;
            acc_reg      <= '0;
            prev_reg     <= '0;
            pass_reg     <= '0;
            second_reg   <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            // result taken by the sink; the result state reloads it itself
            if (m_valid && m_ready && state_reg != ST_RESULT) begin
                m_valid <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg  <= s_kind;
                        now_reg   <= s_now_time;
                        idx_reg   <= s_entry_index;
                        dly_reg   <= s_entry_delay;
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    case (kind_reg)
                        afs_pkg::KIND_SAMPLE: begin
                            if (total_act == '0) begin
                                state_reg <= ST_RESULT;
                            end else if (!started_reg) begin
                                // first sample latches the time and shows frame 0
                                started_reg  <= 1'b1;
                                finished_reg <= 1'b0;
                                cur_reg      <= '0;
                                pass_reg     <= '0;
                                acc_reg      <= '0;
                                prev_reg     <= now_reg;
                                state_reg    <= ST_RESULT;
                            end else if (!finished_reg) begin
                                acc_reg    <= acc_added;
                                prev_reg   <= now_reg;
                                cur_reg    <= cur_fix;
                                second_reg <= 1'b0;
                                state_reg  <= ST_WALK;
                            end else begin
                                state_reg <= ST_RESULT;
                            end
                        end
                        afs_pkg::KIND_RESTART: begin
                            started_reg  <= 1'b0;
                            finished_reg <= 1'b0;
                            cur_reg      <= '0;
                            acc_reg      <= '0;
                            prev_reg     <= '0;
                            pass_reg     <= '0;
                            state_reg    <= ST_RESULT;
                        end
                        default: state_reg <= ST_RESULT;
                    endcase
                end

                ST_WALK: begin
                    cur_reg <= walk_cur_next;
                    if (!covers) begin
                        state_reg <= ST_RESULT;
                    end else begin
                        acc_reg <= acc_reg - XW'(frame_delay);
                        if (pass_end) begin
                            pass_reg <= pass_inc;
                            if (stop_now) begin
                                finished_reg <= 1'b1;
                                state_reg    <= ST_RESULT;
                            end else if (second_reg) begin
                                state_reg <= ST_RESULT;
                            end else begin
                                // wrapped: skip whole passes still covered
                                sum_idx_reg <= '0;
                                sum_reg     <= '0;
                                state_reg   <= ST_SUM;
                            end
                        end
                    end
                end

                ST_SUM: begin
                    sum_reg     <= sum_next;
                    sum_idx_reg <= sum_idx_reg + FW'(1);
                    if (sum_last) begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    if (div_done) begin
                        pass_reg   <= pass_skip;
                        second_reg <= 1'b1;
                        if (capped) begin
                            mul_k_reg <= cap;
                            state_reg <= ST_MUL;
                        end else begin
                            acc_reg   <= XW'(div_rem);
                            state_reg <= ST_WALK;
                        end
                    end
                end

                ST_MUL: begin
                    // capped skip stays below the accumulator, low word is exact
                    prod_reg  <= mul_full[XW-1:0];
                    state_reg <= ST_SUB;
                end

                ST_SUB: begin
                    acc_reg   <= acc_reg - prod_reg;
                    state_reg <= ST_WALK;
                end

                ST_RESULT: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_frame_index <= show ? cur_reg : '0;
                        m_showing     <= show;
                        m_finished    <= show && finished_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
